// File: design/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and the round mixing function for the XTEA
// block decryption core.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_COUNT   = 4;
  localparam int unsigned KEY_SEL_W   = 2;
  localparam int unsigned KEY_INDEX_W = 3;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_SEL_W-1:0] key_sel_t;
  typedef logic [KEY_INDEX_W-1:0] key_index_t;
  typedef word_t [KEY_COUNT-1:0] key_words_t;

  localparam key_words_t KEY_RESET = {
    32'h1357_9BDF,  // key word 3
    32'h2468_ACE0,  // key word 2
    32'h9ABC_DEF0,  // key word 1
    32'h1234_5678   // key word 0
  };

  // ((x << 4) ^ (x >> 5)) + x, modulo 2^32
  function automatic word_t mix_word(input word_t x);
    word_t shuffled;
    begin
      shuffled = (x << 4) ^ (x >> 5);
      mix_word = shuffled + x;
    end
  endfunction

endpackage

// File: design/xtea_key_regs.sv
// ----------------------------------------------------------------------------
// xtea_key_regs
// Four 32-bit key registers behind a plain write port; writes to an index
// past the last key word are dropped.
// ----------------------------------------------------------------------------
module xtea_key_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                write_enable,
  input  xtea_pkg::key_index_t write_index,
  input  xtea_pkg::word_t      write_data,
  output xtea_pkg::key_words_t key_words
);
  import xtea_pkg::*;

  key_words_t keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= KEY_RESET;
    end else if (write_enable && (write_index < key_index_t'(KEY_COUNT))) begin
      keys[write_index[KEY_SEL_W-1:0]] <= write_data;
    end
  end

  assign key_words = keys;

  a_key_write: assert property (@(posedge clk) disable iff (rst)
    (write_enable && (write_index < key_index_t'(KEY_COUNT)))
      |=> (keys[$past(write_index[KEY_SEL_W-1:0])] == $past(write_data)))
    else $error("key register did not take written value");

  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    !write_enable |=> $stable(keys))
    else $error("key registers changed without a write");

endmodule

// File: design/xtea_cell.sv
// ----------------------------------------------------------------------------
// xtea_cell
// One Feistel half-round: subtracts the keyed mix of one word from the
// other and registers both words for the next cell in the row.
// ----------------------------------------------------------------------------
module xtea_cell #(
  parameter logic [31:0] SUM_VAL     = 32'h0,
  parameter logic [1:0]  KEY_SEL     = 2'd0,
  parameter bit          UPDATE_HIGH = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enable,
  input  xtea_pkg::key_words_t key_words,
  input  logic                 in_valid,
  input  xtea_pkg::word_t      in_low,
  input  xtea_pkg::word_t      in_high,
  output logic                 out_valid,
  output xtea_pkg::word_t      out_low,
  output xtea_pkg::word_t      out_high
);
  import xtea_pkg::*;

  word_t source_word;
  word_t target_word;
  word_t round_key;
  word_t updated_word;
  logic  valid;
  word_t low_word;
  word_t high_word;

  always_comb begin
    source_word  = UPDATE_HIGH ? in_low : in_high;
    target_word  = UPDATE_HIGH ? in_high : in_low;
    round_key    = SUM_VAL + key_words[KEY_SEL];
    updated_word = target_word - (mix_word(source_word) ^ round_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      low_word  <= UPDATE_HIGH ? in_low : updated_word;
      high_word <= UPDATE_HIGH ? updated_word : in_high;
    end
  end

  assign out_valid = valid;
  assign out_low   = low_word;
  assign out_high  = high_word;

  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    !enable |=> ($stable(valid) && $stable(low_word) && $stable(high_word)))
    else $error("cell changed while the row was held");

  a_cell_shift: assert property (@(posedge clk) disable iff (rst)
    enable |=> (valid == $past(in_valid)))
    else $error("cell valid did not follow its neighbor");

endmodule

// File: design/xtea_block_decrypt_core.sv
// ----------------------------------------------------------------------------
// xtea_block_decrypt_core
// XTEA decryption of 64-bit blocks under a 128-bit programmable key.
// ----------------------------------------------------------------------------
// A row of 2*ROUND_COUNT half-round cells, one register each, followed by an
// output register. A new ciphertext request is taken every cycle while
// cipher_stall is low; each block passes through the cells in order and then
// the output register before its plaintext appears, the first cell being
// loaded at the accepting edge. The row moves as a whole and only holds
// when its last cell carries a block while the output register still waits
// on the consumer. The user must write key words through the write port only
// while no block is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module xtea_block_decrypt_core #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cipher_valid,
  output logic                 cipher_stall,
  input  xtea_pkg::word_t      cipher_low,
  input  xtea_pkg::word_t      cipher_high,
  output logic                 plain_valid,
  input  logic                 plain_stall,
  output xtea_pkg::word_t      plain_low,
  output xtea_pkg::word_t      plain_high,
  input  logic                 write_enable,
  input  xtea_pkg::key_index_t write_index,
  input  xtea_pkg::word_t      write_data
);
  import xtea_pkg::*;

  localparam int unsigned CELL_COUNT = 2 * ROUND_COUNT;

  key_words_t key_words;
  logic       advance;
  logic       row_valid [0:CELL_COUNT];
  word_t      row_low   [0:CELL_COUNT];
  word_t      row_high  [0:CELL_COUNT];

  logic  out_valid;
  logic  out_valid_next;
  word_t out_low;
  word_t out_high;

  xtea_key_regs u_key_regs (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .key_words    (key_words)
  );

  assign row_valid[0] = cipher_valid;
  assign row_low[0]   = cipher_low;
  assign row_high[0]  = cipher_high;

  // even cells update v1 with the round's sum, odd cells update v0 after the
  // sum has dropped by delta
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    localparam int unsigned SUM_STEPS = ROUND_COUNT - (i / 2) - (i % 2);
    localparam logic [31:0] CELL_SUM =
      32'(64'(XTEA_DELTA) * 64'(SUM_STEPS));
    localparam logic [1:0]  CELL_KEY =
      (i % 2 == 0) ? CELL_SUM[12:11] : CELL_SUM[1:0];

    xtea_cell #(
      .SUM_VAL     (CELL_SUM),
      .KEY_SEL     (CELL_KEY),
      .UPDATE_HIGH ((i % 2) == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .enable    (advance),
      .key_words (key_words),
      .in_valid  (row_valid[i]),
      .in_low    (row_low[i]),
      .in_high   (row_high[i]),
      .out_valid (row_valid[i+1]),
      .out_low   (row_low[i+1]),
      .out_high  (row_high[i+1])
    );
  end

  // the row holds only when a finished block has nowhere to go
  assign advance      = !(row_valid[CELL_COUNT] && out_valid && plain_stall);
  assign cipher_stall = !advance;

  always_comb begin
    if (row_valid[CELL_COUNT] && advance) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !plain_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (row_valid[CELL_COUNT] && advance) begin
      out_low  <= row_low[CELL_COUNT];
      out_high <= row_high[CELL_COUNT];
    end
  end

  assign plain_valid = out_valid;
  assign plain_low   = out_low;
  assign plain_high  = out_high;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output register valid after reset");

  a_hold_cause: assert property (@(posedge clk) disable iff (rst)
    !advance |-> (row_valid[CELL_COUNT] && out_valid && plain_stall))
    else $error("row held without a blocked result");

  a_row_to_out: assert property (@(posedge clk) disable iff (rst)
    (row_valid[CELL_COUNT] && advance) |=>
      (out_valid && out_low == $past(row_low[CELL_COUNT])
                 && out_high == $past(row_high[CELL_COUNT])))
    else $error("finished block not moved to output register");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && plain_stall) |=> out_valid)
    else $error("waiting result lost");

endmodule
